// File: src/tlc_pkg.sv
// Shared types, constants and arithmetic helpers of the trilinear tracker calibration.
`default_nettype none
package tlc_pkg;

  // Grid defaults
  localparam int GRID_X_DEF = 16;
  localparam int GRID_Y_DEF = 16;
  localparam int GRID_Z_DEF = 16;

  // Table memory geometry
  localparam int TABLE_AW = 12;
  localparam int TABLE_DW = 32;

  // Configuration register indexes
  localparam logic [2:0] REG_USE_CAL   = 3'd0;
  localparam logic [2:0] REG_ORIGIN_X  = 3'd1;
  localparam logic [2:0] REG_ORIGIN_Y  = 3'd2;
  localparam logic [2:0] REG_ORIGIN_Z  = 3'd3;
  localparam logic [2:0] REG_INV_SP_X  = 3'd4;
  localparam logic [2:0] REG_INV_SP_Y  = 3'd5;
  localparam logic [2:0] REG_INV_SP_Z  = 3'd6;
  localparam logic [2:0] REG_FILTER_W  = 3'd7;

  // Command codes
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_POS  = 1'b1;

  // Table axis codes
  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  // Special sensors
  localparam logic [3:0] SENSOR_HEAD  = 4'd0;
  localparam logic [3:0] SENSOR_XFORM = 4'd3;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCALE,
    S_INDEX,
    S_READ,
    S_BLEND,
    S_COLLECT,
    S_FILTER,
    S_DONE
  } state_t;

  // Control from the sequencer to a corner blend unit
  typedef struct packed {
    logic       load_en;
    logic       step_en;
    logic [2:0] step;
  } blend_ctrl_t;

  // a + floor(((b - a) * f + 32768) / 65536); result stays between a and b
  function automatic logic signed [31:0] lerp(input logic signed [31:0] a,
                                              input logic signed [31:0] b,
                                              input logic [15:0] f);
    logic signed [32:0] diff;
    logic signed [49:0] prod;
    logic signed [49:0] rnd;
    diff = 33'(b) - 33'(a);
    prod = diff * $signed({1'b0, f});
    rnd  = prod + 50'sd32768;
    return a + $signed(rnd[47:16]);
  endfunction

endpackage
`default_nettype wire

// File: src/tlc_table_mem.sv
// One correction table: 4096 x 32 synchronous memory, shared address, registered read.
`default_nettype none
module tlc_table_mem import tlc_pkg::*; (
  input  wire logic                clk,
  input  wire logic                we,
  input  wire logic [TABLE_AW-1:0] addr,
  input  wire logic [TABLE_DW-1:0] wdata,
  output logic      [TABLE_DW-1:0] rdata
);

  logic [TABLE_DW-1:0] mem [2**TABLE_AW];

  // write and read one entry per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

// File: src/tlc_corner_blend.sv
// Corner queue and shared lerp unit: collects 8 corners, reduces them in 7 steps.
`default_nettype none
module tlc_corner_blend import tlc_pkg::*; (
  input  wire logic               clk,
  input  wire blend_ctrl_t        ctrl,
  input  wire logic [31:0]        rdata,
  input  wire logic [15:0]        fx,
  input  wire logic [15:0]        fy,
  input  wire logic [15:0]        fz,
  output logic signed [31:0]      result
);

  logic signed [31:0] c [8];
  logic        [15:0] f;
  logic signed [31:0] blended;
  logic        [2:0]  slot;

  // steps 0-3 blend along x, 4-5 along y, 6 along z
  always_comb begin
    if (ctrl.step[2] && ctrl.step[1:0] == 2'd2) begin
      f = fz;
    end else if (ctrl.step[2]) begin
      f = fy;
    end else begin
      f = fx;
    end
    blended = lerp(c[0], c[1], f);
    slot    = 3'd6 - ctrl.step;
  end

  // load shifts corners in; a step pops two heads and queues the blend
  always_ff @(posedge clk) begin
    if (ctrl.load_en) begin
      for (int i = 0; i < 7; i++) begin
        c[i] <= c[i+1];
      end
      c[7] <= $signed(rdata);
    end else if (ctrl.step_en) begin
      for (int i = 0; i < 6; i++) begin
        c[i] <= (slot == 3'(i)) ? blended : c[i+2];
      end
      if (slot == 3'd6) begin
        c[6] <= blended;
      end
    end
  end

  assign result = c[0];

endmodule
`default_nettype wire

// File: src/tracker_trilinear_calibration.sv
// Top level: tracker position correction through three trilinear 3D tables.
//
//  channel | dir | fields (low bit up)
//  s_*     | in  | tuser: command; tdata: sensor_index, pos_x, pos_y, pos_z,
//          |     |   table_axis, table_address, table_value
//  m_*     | out | tuser: calibrated; tdata: out_x, out_y, out_z, sensor_out
//  cfg_*   | in  | plain register write, index 0..7
//
// A load item writes its entry and gives no result. A calibrated position runs
// through the shared axis multiplier, the index, the eight corner reads from each
// table memory, the lerp reduction, then collect, optional head filter and
// hand-off. A passed-through position goes to the head filter or hand-off. Reset
// is synchronous; tables are undefined until loaded. A waiting result in the
// output register stalls the block only when the next result is ready.
`default_nettype none
module tracker_trilinear_calibration import tlc_pkg::*; #(
  parameter int GRID_X = GRID_X_DEF,
  parameter int GRID_Y = GRID_Y_DEF,
  parameter int GRID_Z = GRID_Z_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // sensor_index, pos_x, pos_y, pos_z, table_axis, table_address, table_value, pad
  input  wire logic [151:0] s_tdata,
  // command
  input  wire logic         s_tuser,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // out_x, out_y, out_z, sensor_out, pad
  output logic      [103:0] m_tdata,
  // calibrated
  output logic              m_tuser,
  input  wire logic         cfg_we,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [31:0]  cfg_data
);

  localparam int LIN_W = 36 + $clog2(GRID_X * GRID_Y);
  localparam logic signed [LIN_W-1:0] GX_L    = LIN_W'(GRID_X);
  localparam logic signed [LIN_W-1:0] GXY_L   = LIN_W'(GRID_X * GRID_Y);
  localparam logic signed [LIN_W-1:0] SPAN_L  = LIN_W'(1 + GRID_X + GRID_X * GRID_Y);
  localparam logic signed [LIN_W-1:0] TOTAL_L = LIN_W'(GRID_X * GRID_Y * GRID_Z);
  localparam logic [TABLE_AW-1:0]     SY_A    = TABLE_AW'(GRID_X);
  localparam logic [TABLE_AW-1:0]     SZ_A    = TABLE_AW'(GRID_X * GRID_Y);

  // input fields
  logic        in_cmd;
  logic [3:0]  in_sensor;
  logic signed [31:0] in_px, in_py, in_pz;
  logic [1:0]  in_axis;
  logic [TABLE_AW-1:0] in_addr;
  logic [31:0] in_value;

  assign in_cmd    = s_tuser;
  assign in_sensor = s_tdata[3:0];
  assign in_px     = $signed(s_tdata[35:4]);
  assign in_py     = $signed(s_tdata[67:36]);
  assign in_pz     = $signed(s_tdata[99:68]);
  assign in_axis   = s_tdata[101:100];
  assign in_addr   = s_tdata[113:102];
  assign in_value  = s_tdata[145:114];

  // configuration registers
  logic        use_cal;
  logic signed [31:0] origin [3];
  logic [31:0] inv_sp [3];
  logic [15:0] filter_w;

  always_ff @(posedge clk) begin
    if (rst) begin
      use_cal   <= 1'b0;
      origin[0] <= '0;
      origin[1] <= '0;
      origin[2] <= '0;
      inv_sp[0] <= 32'h0001_0000;
      inv_sp[1] <= 32'h0001_0000;
      inv_sp[2] <= 32'h0001_0000;
      filter_w  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_USE_CAL:  use_cal   <= cfg_data[0];
        REG_ORIGIN_X: origin[0] <= $signed(cfg_data);
        REG_ORIGIN_Y: origin[1] <= $signed(cfg_data);
        REG_ORIGIN_Z: origin[2] <= $signed(cfg_data);
        REG_INV_SP_X: inv_sp[0] <= cfg_data;
        REG_INV_SP_Y: inv_sp[1] <= cfg_data;
        REG_INV_SP_Z: inv_sp[2] <= cfg_data;
        REG_FILTER_W: filter_w  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // sequencer state and working registers
  state_t state, state_next;
  logic [1:0]  ax;
  logic [3:0]  rd_cnt;
  logic [2:0]  bl_cnt;
  logic [3:0]  sensor;
  logic signed [31:0] pos [3];
  logic signed [33:0] ix_r [3];
  logic [15:0] frac_r [3];
  logic [TABLE_AW-1:0] lin_a;
  logic signed [31:0] res_x, res_y, res_z;
  logic        res_cal;
  logic signed [31:0] prev_y;
  logic        prev_valid;
  logic        out_valid;
  logic signed [31:0] ox, oy, oz;
  logic        ocal;
  logic [3:0]  osens;

  logic accept;
  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;

  // shared axis scaling multiplier: (p - origin) * inv_spacing
  logic signed [32:0] d;
  logic signed [65:0] prod;
  always_comb begin
    d    = 33'(pos[ax]) - 33'(origin[ax]);
    prod = d * $signed({1'b0, inv_sp[ax]});
  end

  // linear index and bounds check
  logic signed [LIN_W-1:0] lin, lin_span;
  logic in_range;
  always_comb begin
    lin      = LIN_W'(ix_r[0]) + LIN_W'(ix_r[1]) * GX_L + LIN_W'(ix_r[2]) * GXY_L;
    lin_span = lin + SPAN_L;
    in_range = !lin[LIN_W-1] && (lin_span < TOTAL_L);
  end

  // corner address
  logic [2:0] corner;
  logic [TABLE_AW-1:0] ofs, raddr, mem_addr;
  always_comb begin
    corner = rd_cnt[2:0];
    ofs = (corner[0] ? TABLE_AW'(1) : '0) + (corner[1] ? SY_A : '0)
        + (corner[2] ? SZ_A : '0);
    raddr = lin_a + ofs;
    mem_addr = (state == S_IDLE) ? in_addr : raddr;
  end

  // table memories
  logic we_x, we_y, we_z;
  logic [31:0] rd_x, rd_y, rd_z;
  assign we_x = accept && in_cmd == CMD_LOAD && in_axis == AXIS_X;
  assign we_y = accept && in_cmd == CMD_LOAD && in_axis == AXIS_Y;
  assign we_z = accept && in_cmd == CMD_LOAD && in_axis == AXIS_Z;

  tlc_table_mem u_mem_x (.clk, .we(we_x), .addr(mem_addr), .wdata(in_value), .rdata(rd_x));
  tlc_table_mem u_mem_y (.clk, .we(we_y), .addr(mem_addr), .wdata(in_value), .rdata(rd_y));
  tlc_table_mem u_mem_z (.clk, .we(we_z), .addr(mem_addr), .wdata(in_value), .rdata(rd_z));

  // corner blend units
  blend_ctrl_t bctrl;
  logic signed [31:0] bl_x, bl_y, bl_z;
  always_comb begin
    bctrl.load_en = (state == S_READ) && (rd_cnt != 4'd0);
    bctrl.step_en = (state == S_BLEND);
    bctrl.step    = bl_cnt;
  end

  tlc_corner_blend u_bl_x (.clk, .ctrl(bctrl), .rdata(rd_x), .fx(frac_r[0]),
                           .fy(frac_r[1]), .fz(frac_r[2]), .result(bl_x));
  tlc_corner_blend u_bl_y (.clk, .ctrl(bctrl), .rdata(rd_y), .fx(frac_r[0]),
                           .fy(frac_r[1]), .fz(frac_r[2]), .result(bl_y));
  tlc_corner_blend u_bl_z (.clk, .ctrl(bctrl), .rdata(rd_z), .fx(frac_r[0]),
                           .fy(frac_r[1]), .fz(frac_r[2]), .result(bl_z));

  // head y filter
  logic signed [31:0] y_filt;
  assign y_filt = prev_valid ? lerp(res_y, prev_y, filter_w) : res_y;

  logic out_free;
  assign out_free = !out_valid || m_tready;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && in_cmd == CMD_POS) begin
          if (in_sensor != SENSOR_XFORM && use_cal) begin
            state_next = S_SCALE;
          end else if (in_sensor == SENSOR_HEAD) begin
            state_next = S_FILTER;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_SCALE: begin
        if (ax == 2'd2) state_next = S_INDEX;
      end
      S_INDEX: begin
        if (in_range) begin
          state_next = S_READ;
        end else if (sensor == SENSOR_HEAD) begin
          state_next = S_FILTER;
        end else begin
          state_next = S_DONE;
        end
      end
      S_READ: begin
        if (rd_cnt == 4'd8) state_next = S_BLEND;
      end
      S_BLEND: begin
        if (bl_cnt == 3'd6) state_next = S_COLLECT;
      end
      S_COLLECT: begin
        state_next = (sensor == SENSOR_HEAD) ? S_FILTER : S_DONE;
      end
      S_FILTER: state_next = S_DONE;
      S_DONE: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // control counters and filter state
  always_ff @(posedge clk) begin
    if (rst) begin
      ax         <= '0;
      rd_cnt     <= '0;
      bl_cnt     <= '0;
      prev_valid <= 1'b0;
      prev_y     <= '0;
      out_valid  <= 1'b0;
    end else begin
      ax     <= (state == S_SCALE) ? ax + 2'd1 : '0;
      rd_cnt <= (state == S_READ) ? rd_cnt + 4'd1 : '0;
      bl_cnt <= (state == S_BLEND) ? bl_cnt + 3'd1 : '0;
      if (state == S_FILTER) begin
        prev_y     <= y_filt;
        prev_valid <= 1'b1;
      end
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      sensor <= in_sensor;
      pos[0] <= in_px;
      pos[1] <= in_py;
      pos[2] <= in_pz;
      res_x  <= in_px;
      res_y  <= in_py;
      res_z  <= in_pz;
      res_cal <= 1'b0;
    end
    if (state == S_SCALE) begin
      ix_r[ax]   <= prod[65:32];
      frac_r[ax] <= prod[31:16];
    end
    if (state == S_INDEX) begin
      lin_a <= lin[TABLE_AW-1:0];
    end
    if (state == S_COLLECT) begin
      res_x   <= bl_x;
      res_y   <= bl_y;
      res_z   <= bl_z;
      res_cal <= 1'b1;
    end
    if (state == S_FILTER) begin
      res_y <= y_filt;
    end
    if (state == S_DONE && out_free) begin
      ox    <= res_x;
      oy    <= res_y;
      oz    <= res_z;
      ocal  <= res_cal;
      osens <= sensor;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {4'b0000, osens, oz, oy, ox};
  assign m_tuser  = ocal;

  // the transform sensor is never calibrated
  a_xform_uncal: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[99:96] != SENSOR_XFORM)
    else $error("transform sensor reported as calibrated");

  // corner reads start only after a passing bounds check
  a_read_entry: assert property (@(posedge clk) disable iff (rst)
    state == S_READ && rd_cnt == 4'd0 |-> $past(state) == S_INDEX && $past(in_range))
    else $error("corner read without bounds check");

  // no item is taken while the sequencer is busy
  a_busy: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> !s_tready)
    else $error("input ready while busy");

endmodule
`default_nettype wire

// File: test/tracker_trilinear_calibration_tb.sv
// Testbench for tracker_trilinear_calibration: directed and random loads and positions.
`default_nettype none
module tracker_trilinear_calibration_tb;
  import tlc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int GX = 16, GY = 16, GZ = 16;
  localparam int CYCLE_LIMIT = 1500000;
  // cell one step left of the grid on x, at y 2, z 2
  localparam int WRAP_LIN = GX * 2 + GX * GY * 2 - 1;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic        cal;
    logic [3:0]  sensor;
  } corr_pos_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [151:0] s_tdata = '0;
  logic         s_tuser = 1'b0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [103:0] m_tdata;
  logic         m_tuser;
  logic         cfg_we = 1'b0;
  logic [2:0]   cfg_index = '0;
  logic [31:0]  cfg_data = '0;

  tracker_trilinear_calibration u_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // model state
  logic [31:0] tab_x [4096];
  logic [31:0] tab_y [4096];
  logic [31:0] tab_z [4096];
  bit          written [3][4096];
  logic signed [63:0] head_y_prev;
  bit          head_valid;
  bit          cal_on;
  logic signed [63:0] org [3];
  logic [63:0] inv [3];
  logic [63:0] filt_w;

  corr_pos_t   expected_q[$];
  int          errors = 0;
  int          results_seen = 0;
  int          cycles = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  bit          hold_recv = 1'b0;

  function automatic logic signed [63:0] fshift(input logic signed [63:0] v);
    return v >>> 16;
  endfunction

  function automatic logic signed [63:0] mix(input logic signed [63:0] a,
                                             input logic signed [63:0] b,
                                             input logic signed [63:0] f);
    return a + fshift((b - a) * f + 64'sd32768);
  endfunction

  function automatic logic signed [63:0] scaled(input logic signed [63:0] p, input int ax);
    logic signed [63:0] d, hi, lo;
    d  = p - org[ax];
    hi = $signed({16'd0, inv[ax][63:16]});
    lo = $signed({48'd0, inv[ax][15:0]});
    return d * hi + fshift(d * lo);
  endfunction

  function automatic logic signed [63:0] corner_mix(input int ax, input logic signed [63:0] lin,
      input logic signed [63:0] fx, input logic signed [63:0] fy, input logic signed [63:0] fz);
    logic signed [63:0] c [8];
    logic signed [63:0] idx;
    logic [31:0] raw;
    for (int i = 0; i < 8; i++) begin
      idx = lin + (i & 1) + ((i & 2) ? GX : 0) + ((i & 4) ? GX * GY : 0);
      raw = (ax == 0) ? tab_x[idx[11:0]] : (ax == 1) ? tab_y[idx[11:0]] : tab_z[idx[11:0]];
      c[i] = $signed(raw);
    end
    return mix(mix(mix(c[0], c[1], fx), mix(c[2], c[3], fx), fy),
               mix(mix(c[4], c[5], fx), mix(c[6], c[7], fx), fy), fz);
  endfunction

  // lin if in range, else -1
  function automatic logic signed [63:0] grid_cell(input logic [31:0] px, input logic [31:0] py,
                                                   input logic [31:0] pz);
    logic signed [63:0] bx, by, bz, lin;
    bx = scaled($signed(px), 0);
    by = scaled($signed(py), 1);
    bz = scaled($signed(pz), 2);
    lin = fshift(bx) + GX * fshift(by) + GX * GY * fshift(bz);
    if (lin < 0 || lin + 1 + GX + GX * GY >= GX * GY * GZ) return -1;
    return lin;
  endfunction

  // all eight corners of a cell loaded in all three tables
  function automatic bit corners_loaded(input logic signed [63:0] lin);
    logic signed [63:0] idx;
    bit ok;
    ok = 1'b1;
    for (int i = 0; i < 8; i++) begin
      idx = lin + (i & 1) + ((i & 2) ? GX : 0) + ((i & 4) ? GX * GY : 0);
      for (int t = 0; t < 3; t++)
        if (!written[t][idx[11:0]]) ok = 1'b0;
    end
    return ok;
  endfunction

  // predict the result of one accepted item
  task automatic predict_item(input logic cmd, input logic [151:0] d);
    logic [3:0] sensor;
    logic [31:0] px, py, pz;
    logic signed [63:0] rx, ry, rz, lin, bx, by, bz;
    corr_pos_t r;
    sensor = d[3:0];
    px = d[35:4]; py = d[67:36]; pz = d[99:68];
    if (cmd == CMD_LOAD) begin
      case (d[101:100])
        AXIS_X: tab_x[d[113:102]] = d[145:114];
        AXIS_Y: tab_y[d[113:102]] = d[145:114];
        AXIS_Z: tab_z[d[113:102]] = d[145:114];
        default: ;
      endcase
      return;
    end
    rx = $signed(px); ry = $signed(py); rz = $signed(pz);
    r.cal = 1'b0;
    if (sensor != SENSOR_XFORM) begin
      lin = cal_on ? grid_cell(px, py, pz) : -1;
      if (lin >= 0) begin
        bx = scaled($signed(px), 0);
        by = scaled($signed(py), 1);
        bz = scaled($signed(pz), 2);
        rx = corner_mix(0, lin, bx[15:0], by[15:0], bz[15:0]);
        ry = corner_mix(1, lin, bx[15:0], by[15:0], bz[15:0]);
        rz = corner_mix(2, lin, bx[15:0], by[15:0], bz[15:0]);
        r.cal = 1'b1;
      end
      if (sensor == SENSOR_HEAD) begin
        if (head_valid)
          ry = ry + fshift((head_y_prev - ry) * $signed(filt_w) + 64'sd32768);
        head_y_prev = ry;
        head_valid = 1'b1;
      end
    end
    r.x = rx[31:0]; r.y = ry[31:0]; r.z = rz[31:0]; r.sensor = sensor;
    expected_q.push_back(r);
  endtask

  // write one register while idle
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    s_tvalid <= 1'b0;
    @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_USE_CAL:  cal_on = val[0];
      REG_ORIGIN_X: org[0] = $signed(val);
      REG_ORIGIN_Y: org[1] = $signed(val);
      REG_ORIGIN_Z: org[2] = $signed(val);
      REG_INV_SP_X: inv[0] = val;
      REG_INV_SP_Y: inv[1] = val;
      REG_INV_SP_Z: inv[2] = val;
      REG_FILTER_W: filt_w = val[15:0];
      default: ;
    endcase
  endtask

  // send one item, idling before it at random
  task automatic send_item(input logic cmd, input logic [151:0] d);
    logic signed [63:0] lin;
    lin = -1;
    if (cmd == CMD_POS && cal_on && d[3:0] != SENSOR_XFORM)
      lin = grid_cell(d[35:4], d[67:36], d[99:68]);
    // positions on cells whose corners were never loaded are not sent
    if (lin >= 0 && !corners_loaded(lin)) return;
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1; s_tuser <= cmd; s_tdata <= d;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_item(cmd, d);
  endtask

  function automatic logic [151:0] pack_pos(input logic [3:0] s, input logic [31:0] x,
                                            input logic [31:0] y, input logic [31:0] z);
    return {6'd0, $urandom(), 12'($urandom()), 2'($urandom()), z, y, x, s};
  endfunction

  function automatic logic [151:0] pack_load(input logic [1:0] ax, input logic [11:0] a,
                                             input logic [31:0] v);
    return {6'd0, v, a, ax, $urandom(), $urandom(), $urandom(), 4'($urandom())};
  endfunction

  task automatic send_load(input logic [1:0] ax, input logic [11:0] a, input logic [31:0] v);
    send_item(CMD_LOAD, pack_load(ax, a, v));
    if (ax != 2'd3) written[ax][a] = 1'b1;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // position on grid cell (cx,cy,cz) with identity origin 0 and spacing 1.0
  function automatic logic [31:0] coord(input int c);
    return {16'(c), 16'($urandom())};
  endfunction

  // load the low 4x4x4 corner block of all three tables and one wrapped cell
  task automatic test_fill_tables();
    int base;
    for (int a = 0; a < 64; a++) begin
      base = (a & 3) + GX * ((a >> 2) & 3) + GX * GY * (a >> 4);
      for (int ax = 0; ax < 3; ax++)
        send_load(2'(ax), 12'(base), $urandom());
    end
    for (int i = 0; i < 8; i++) begin
      base = WRAP_LIN + (i & 1) + ((i & 2) ? GX : 0) + ((i & 4) ? GX * GY : 0);
      for (int ax = 0; ax < 3; ax++)
        send_load(2'(ax), 12'(base), $urandom());
    end
  endtask

  task automatic test_directed();
    logic [31:0] ext [4] = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff};
    // on the first run: passthrough with calibration off, extremes, head first sample
    foreach (ext[i]) send_item(CMD_POS, pack_pos(4'(i * 5), ext[i], ext[3 - i], ext[i]));
    send_item(CMD_POS, pack_pos(SENSOR_HEAD, 0, 32'h7fff_ffff, 0));
    send_item(CMD_POS, pack_pos(4'd15, 1, 2, 3));
    // ignored table axis three
    send_load(2'd3, 12'd4095, 32'hdead_beef);
    drain();
    write_reg(REG_USE_CAL, 1);
    write_reg(REG_FILTER_W, 16'hffff);
    // in grid, edge of grid, out of grid, sensor three, head filter
    send_item(CMD_POS, pack_pos(SENSOR_HEAD, coord(0), coord(0), coord(0)));
    send_item(CMD_POS, pack_pos(SENSOR_HEAD, coord(2), coord(2), coord(2)));
    send_item(CMD_POS, pack_pos(4'd1, coord(15), coord(14), coord(14)));
    send_item(CMD_POS, pack_pos(4'd2, coord(3), coord(3), coord(15)));
    send_item(CMD_POS, pack_pos(SENSOR_XFORM, coord(5), coord(5), coord(5)));
    send_item(CMD_POS, pack_pos(4'd7, 32'hffff_0000, coord(2), coord(2)));
    send_item(CMD_POS, pack_pos(4'd15, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff));
    send_item(CMD_POS, pack_pos(SENSOR_HEAD, coord(1), coord(1), coord(1)));
    drain();
    write_reg(REG_FILTER_W, 0);
  endtask

  // random positions, mostly inside the loaded cells, mixed with random table loads
  task automatic test_random(input int n);
    logic [3:0] s;
    for (int i = 0; i < n; i++) begin
      s = ($urandom_range(3) == 0) ? SENSOR_HEAD : 4'($urandom());
      if ($urandom_range(9) == 0)
        send_load(2'($urandom()), 12'($urandom()), $urandom());
      else if ($urandom_range(4) == 0)
        send_item(CMD_POS, pack_pos(s, $urandom(), $urandom(), $urandom()));
      else
        send_item(CMD_POS, pack_pos(s, coord($urandom_range(2)), coord($urandom_range(2)),
                                    coord($urandom_range(2))));
    end
  endtask

  // settings sweep: scaled grid with origin, then extremes
  task automatic test_settings();
    write_reg(REG_ORIGIN_X, 32'hfffc_0000);
    write_reg(REG_ORIGIN_Y, 32'h0002_0000);
    write_reg(REG_ORIGIN_Z, 32'h0000_8000);
    write_reg(REG_INV_SP_X, 32'h0002_0000);
    write_reg(REG_INV_SP_Y, 32'h0000_8000);
    write_reg(REG_INV_SP_Z, 32'h0001_4000);
    write_reg(REG_FILTER_W, 16'h8000);
    for (int i = 0; i < 150; i++)
      send_item(CMD_POS, pack_pos(4'($urandom()),
                32'(int'($urandom_range(3 << 15)) - (4 << 16)),
                32'(int'($urandom_range(6 << 16)) + (2 << 16)),
                32'($urandom_range(3 << 16))));
    drain();
    write_reg(REG_ORIGIN_X, 32'h8000_0000);
    write_reg(REG_ORIGIN_Y, 32'h7fff_ffff);
    write_reg(REG_ORIGIN_Z, 32'h0);
    write_reg(REG_INV_SP_X, 32'hffff_ffff);
    write_reg(REG_INV_SP_Y, 32'h0);
    write_reg(REG_INV_SP_Z, 32'h0);
    write_reg(REG_FILTER_W, 16'hffff);
    for (int i = 0; i < 50; i++)
      send_item(CMD_POS, pack_pos(4'($urandom()), $urandom_range(3), $urandom(), $urandom()));
    drain();
    // back to identity grid
    for (int a = 0; a < 3; a++) begin
      write_reg(3'(REG_ORIGIN_X + a), 0);
      write_reg(3'(REG_INV_SP_X + a), 32'h0001_0000);
    end
  endtask

  // receiver holds off while the sender keeps offering
  task automatic test_backpressure();
    hold_recv = 1'b1;
    fork
      test_random(20);
      begin
        repeat (400) @(posedge clk);
        hold_recv = 1'b0;
      end
    join
    drain();
  endtask

  // result checker
  always @(posedge clk) begin
    corr_pos_t got, want;
    cycles <= cycles + 1;
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tdata[31:0], m_tdata[63:32], m_tdata[95:64], m_tuser, m_tdata[99:96]};
      results_seen++;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
      end else begin
        want = expected_q.pop_front();
        if (got.x !== want.x)
          $display("%0t: out_x expected %h actual %h", $time, want.x, got.x);
        if (got.y !== want.y)
          $display("%0t: out_y expected %h actual %h", $time, want.y, got.y);
        if (got.z !== want.z)
          $display("%0t: out_z expected %h actual %h", $time, want.z, got.z);
        if (got.cal !== want.cal)
          $display("%0t: calibrated expected %b actual %b", $time, want.cal, got.cal);
        if (got.sensor !== want.sensor)
          $display("%0t: sensor_out expected %h actual %h", $time, want.sensor, got.sensor);
        if (got !== want) errors++;
      end
    end
    m_tready <= !hold_recv && ($urandom_range(99) >= recv_idle_pct);
  end

  // timeout
  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("tracker_trilinear_calibration_tb: errors");
      $finish;
    end
  end

  initial begin
    cal_on = 0; filt_w = 0; head_valid = 0; head_y_prev = 0;
    for (int a = 0; a < 3; a++) begin
      org[a] = 0;
      inv[a] = 64'h1_0000;
    end
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_fill_tables();
    test_directed();
    drain();
    test_directed();
    send_idle_pct = 26; recv_idle_pct = 75;
    test_random(400);
    drain();
    test_settings();
    send_idle_pct = 75; recv_idle_pct = 26;
    test_random(400);
    drain();
    write_reg(REG_USE_CAL, 0);
    test_random(60);
    drain();
    write_reg(REG_USE_CAL, 1);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_backpressure();
    test_random(350);
    drain();
    $display("covered table loads, pass-through, calibrated blends, head filter,");
    $display("grid bounds, register extremes and stalls; %0d results checked", results_seen);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("tracker_trilinear_calibration_tb: clean");
    end else begin
      $display("tracker_trilinear_calibration_tb: errors");
    end
    $finish;
  end
endmodule
`default_nettype wire

// File: files.f
src/tlc_pkg.sv
src/tlc_table_mem.sv
src/tlc_corner_blend.sv
src/tracker_trilinear_calibration.sv
test/tracker_trilinear_calibration_tb.sv
